// File: rtl/msp_pkg.sv
package msp_pkg;

	localparam int REG_BITS = 24;
	localparam int INDEX_BITS = 12;
	localparam int CFG_INDEX_BITS = 2;

	localparam int DEF_MAX_POINTS = 4096;
	localparam int DEF_COORD_BITS = 24;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_X = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_Y = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_Z = 2'd2;

	localparam logic signed [REG_BITS-1:0] AXIS_X_RESET = 24'sd4096;
	localparam logic signed [REG_BITS-1:0] AXIS_Y_RESET = 24'sd0;
	localparam logic signed [REG_BITS-1:0] AXIS_Z_RESET = 24'sd0;

	typedef enum logic [1:0] {
		KIND_SET_A = 2'd0,
		KIND_SET_B = 2'd1,
		KIND_DIFF  = 2'd2
	} result_kind_t;

	typedef struct packed {
		logic valid;
		logic carries_point;
		logic set_select;
		logic end_of_query;
	} item_ctrl_t;

endpackage

// File: rtl/msp_dot.sv
module msp_dot #(
	parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [msp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [msp_pkg::REG_BITS-1:0]          cfg_wdata,
	input  logic                                  adv,
	input  msp_pkg::item_ctrl_t                   ctrl_in,
	input  logic signed [COORD_BITS-1:0]          pt_in [3],
	output msp_pkg::item_ctrl_t                   ctrl_s3,
	output logic signed [COORD_BITS-1:0]          pt_s3 [3],
	output logic signed [COORD_BITS+25:0]         score_s3
);

	localparam int PROD_W = COORD_BITS + msp_pkg::REG_BITS;
	localparam int SCORE_W = COORD_BITS + 26;

	logic signed [msp_pkg::REG_BITS-1:0] axis_q [3];

	msp_pkg::item_ctrl_t ctrl_s1, ctrl_s2;
	logic signed [COORD_BITS-1:0] pt_s1 [3];
	logic signed [COORD_BITS-1:0] pt_s2 [3];
	logic signed [PROD_W-1:0]     prod [3];
	logic signed [PROD_W-1:0]     prod_s2 [3];
	logic signed [SCORE_W-1:0]    sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] <= msp_pkg::AXIS_X_RESET;
			axis_q[1] <= msp_pkg::AXIS_Y_RESET;
			axis_q[2] <= msp_pkg::AXIS_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				msp_pkg::CFG_AXIS_X: axis_q[0] <= cfg_wdata;
				msp_pkg::CFG_AXIS_Y: axis_q[1] <= cfg_wdata;
				msp_pkg::CFG_AXIS_Z: axis_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// one multiplier per axis component, registered before the sum
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			prod[k] = PROD_W'(pt_s1[k]) * PROD_W'(axis_q[k]);
		end
		sum = SCORE_W'(prod_s2[0]) + SCORE_W'(prod_s2[1]) + SCORE_W'(prod_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				pt_s1[k]   <= pt_in[k];
				pt_s2[k]   <= pt_s1[k];
				prod_s2[k] <= prod[k];
				pt_s3[k]   <= pt_s2[k];
			end
			// set b is scored along the negated axis
			score_s3 <= ctrl_s2.set_select ? -sum : sum;
		end
	end

endmodule

// File: rtl/msp_track.sv
module msp_track #(
	parameter int MAX_POINTS = msp_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  msp_pkg::item_ctrl_t                 ctrl_s3,
	input  logic signed [COORD_BITS-1:0]        pt_s3 [3],
	input  logic signed [COORD_BITS+25:0]       score_s3,
	output logic                                cap,
	output logic signed [COORD_BITS-1:0]        far_pt [2][3],
	output logic [msp_pkg::INDEX_BITS-1:0]      far_idx [2],
	output logic signed [COORD_BITS-1:0]        near_pt [2][3],
	output logic [msp_pkg::INDEX_BITS-1:0]      near_idx [2]
);

	localparam int CNT_W = $clog2(MAX_POINTS);
	localparam int SCORE_W = COORD_BITS + 26;
	localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_POINTS - 1);

	logic [CNT_W-1:0]          cnt_q [2];
	logic                      seen_q [2];
	logic signed [SCORE_W-1:0] bmax_q [2];
	logic signed [SCORE_W-1:0] bmin_q [2];
	logic signed [COORD_BITS-1:0] maxpt_q [2][3];
	logic signed [COORD_BITS-1:0] minpt_q [2][3];
	logic [CNT_W-1:0]          maxidx_q [2];
	logic [CNT_W-1:0]          minidx_q [2];

	logic [CNT_W-1:0]          cnt_n [2];
	logic                      seen_n [2];
	logic signed [SCORE_W-1:0] bmax_n [2];
	logic signed [SCORE_W-1:0] bmin_n [2];
	logic signed [COORD_BITS-1:0] maxpt_n [2][3];
	logic signed [COORD_BITS-1:0] minpt_n [2][3];
	logic [CNT_W-1:0]          maxidx_n [2];
	logic [CNT_W-1:0]          minidx_n [2];

	logic take;
	logic sel;

	assign take = adv && ctrl_s3.valid;
	assign sel  = ctrl_s3.set_select;
	assign cap  = take && ctrl_s3.end_of_query;

	always_comb begin
		cnt_n    = cnt_q;
		seen_n   = seen_q;
		bmax_n   = bmax_q;
		bmin_n   = bmin_q;
		maxpt_n  = maxpt_q;
		minpt_n  = minpt_q;
		maxidx_n = maxidx_q;
		minidx_n = minidx_q;
		if (ctrl_s3.carries_point) begin
			if (cnt_q[sel] != CNT_TOP) begin
				cnt_n[sel] = cnt_q[sel] + 1'b1;
			end
			// strict compares keep the earlier point on a tie
			if (!seen_q[sel] || score_s3 > bmax_q[sel]) begin
				bmax_n[sel]   = score_s3;
				maxidx_n[sel] = cnt_q[sel];
				maxpt_n[sel]  = pt_s3;
			end
			if (!seen_q[sel] || score_s3 < bmin_q[sel]) begin
				bmin_n[sel]   = score_s3;
				minidx_n[sel] = cnt_q[sel];
				minpt_n[sel]  = pt_s3;
			end
			seen_n[sel] = 1'b1;
		end
	end

	// an empty set reports zeros
	always_comb begin
		for (int s = 0; s < 2; s++) begin
			for (int k = 0; k < 3; k++) begin
				far_pt[s][k]  = seen_n[s] ? maxpt_n[s][k] : '0;
				near_pt[s][k] = seen_n[s] ? minpt_n[s][k] : '0;
			end
			far_idx[s]  = seen_n[s] ? msp_pkg::INDEX_BITS'(maxidx_n[s]) : '0;
			near_idx[s] = seen_n[s] ? msp_pkg::INDEX_BITS'(minidx_n[s]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				cnt_q[s]  <= '0;
				seen_q[s] <= 1'b0;
			end
		end else if (take) begin
			for (int s = 0; s < 2; s++) begin
				cnt_q[s]  <= ctrl_s3.end_of_query ? '0 : cnt_n[s];
				seen_q[s] <= ctrl_s3.end_of_query ? 1'b0 : seen_n[s];
			end
		end
	end

	// kept points only count while their seen flag is set
	always_ff @(posedge clk) begin
		if (take) begin
			bmax_q   <= bmax_n;
			bmin_q   <= bmin_n;
			maxpt_q  <= maxpt_n;
			minpt_q  <= minpt_n;
			maxidx_q <= maxidx_n;
			minidx_q <= minidx_n;
		end
	end

endmodule

// File: rtl/msp_emit.sv
module msp_emit #(
	parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cap,
	input  logic signed [COORD_BITS-1:0]        far_pt [2][3],
	input  logic [msp_pkg::INDEX_BITS-1:0]      far_idx [2],
	input  logic signed [COORD_BITS-1:0]        near_pt [2][3],
	input  logic [msp_pkg::INDEX_BITS-1:0]      near_idx [2],
	output logic                                busy,
	input  logic                                out_ready,
	output logic                                out_valid,
	output msp_pkg::result_kind_t               out_kind,
	output logic signed [COORD_BITS:0]          out_far [3],
	output logic [msp_pkg::INDEX_BITS-1:0]      out_far_idx,
	output logic signed [COORD_BITS-1:0]        out_near [3],
	output logic [msp_pkg::INDEX_BITS-1:0]      out_near_idx,
	output logic                                out_last
);

	localparam int FAR_W = COORD_BITS + 1;

	logic signed [COORD_BITS-1:0]     far_q [2][3];
	logic signed [COORD_BITS-1:0]     near_q [2][3];
	logic [msp_pkg::INDEX_BITS-1:0]   far_idx_q [2];
	logic [msp_pkg::INDEX_BITS-1:0]   near_idx_q [2];
	logic                             busy_q;
	logic                             out_valid_q;
	msp_pkg::result_kind_t            kind_q, kind_n;

	logic signed [FAR_W-1:0]          sel_far [3];
	logic signed [COORD_BITS-1:0]     sel_near [3];
	logic [msp_pkg::INDEX_BITS-1:0]   sel_far_idx, sel_near_idx;
	logic                             ld;

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign ld        = busy_q && (!out_valid_q || out_ready);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sel_far[k]  = '0;
			sel_near[k] = '0;
		end
		sel_far_idx  = '0;
		sel_near_idx = '0;
		kind_n       = msp_pkg::KIND_DIFF;
		case (kind_q)
			msp_pkg::KIND_SET_A: begin
				for (int k = 0; k < 3; k++) begin
					sel_far[k]  = FAR_W'(far_q[0][k]);
					sel_near[k] = near_q[0][k];
				end
				sel_far_idx  = far_idx_q[0];
				sel_near_idx = near_idx_q[0];
				kind_n       = msp_pkg::KIND_SET_B;
			end
			msp_pkg::KIND_SET_B: begin
				for (int k = 0; k < 3; k++) begin
					sel_far[k]  = FAR_W'(far_q[1][k]);
					sel_near[k] = near_q[1][k];
				end
				sel_far_idx  = far_idx_q[1];
				sel_near_idx = near_idx_q[1];
				kind_n       = msp_pkg::KIND_DIFF;
			end
			msp_pkg::KIND_DIFF: begin
				// minkowski difference of the two supports
				for (int k = 0; k < 3; k++) begin
					sel_far[k] = FAR_W'(far_q[0][k]) - FAR_W'(far_q[1][k]);
				end
				kind_n = msp_pkg::KIND_DIFF;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			kind_q      <= msp_pkg::KIND_SET_A;
			out_valid_q <= 1'b0;
		end else begin
			if (cap) begin
				busy_q <= 1'b1;
				kind_q <= msp_pkg::KIND_SET_A;
			end else if (ld) begin
				kind_q <= kind_n;
				if (kind_q == msp_pkg::KIND_DIFF) begin
					busy_q <= 1'b0;
				end
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			far_q      <= far_pt;
			near_q     <= near_pt;
			far_idx_q  <= far_idx;
			near_idx_q <= near_idx;
		end
		if (ld) begin
			out_kind     <= kind_q;
			out_far      <= sel_far;
			out_near     <= sel_near;
			out_far_idx  <= sel_far_idx;
			out_near_idx <= sel_near_idx;
			out_last     <= (kind_q == msp_pkg::KIND_DIFF);
		end
	end

endmodule

// File: rtl/minkowski_support_point.sv
// Streaming support-point search over two point sets. Each request may carry one
// point tagged for set A or set B; it is scored by its dot product with the
// axis registers (set B along the negated axis), and each set keeps its first
// highest and first lowest scoring point with their indices. A request with
// tlast closes the query and yields three results: set A support, set B support
// and the difference of the two furthest points, the last with tlast set. One
// request is accepted per clock unless the pipeline holds; a request passes the
// input register, multiplier stage and sum stage to reach the running extremes.
// The three results of a query leave the output register one after another, so
// a second closing request stalls at the last stage until the previous query's
// results have all entered the output register. Axis writes take effect at once;
// the user must make them only while no request is in flight; it is not enforced.
module minkowski_support_point #(
	parameter int MAX_POINTS = msp_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = msp_pkg::DEF_COORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [msp_pkg::REG_BITS-1:0]      cfg_wdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// point_x, point_y, point_z
	input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	// set_select, carries_point
	input  logic [1:0]                        s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// furthest_x, furthest_y, furthest_z, far_point_index,
	// closest_x, closest_y, closest_z, near_point_index
	output logic [((6*COORD_BITS+27+7)/8)*8-1:0] m_axis_tdata,
	// result_kind
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	localparam int OUT_W = ((6*COORD_BITS+27+7)/8)*8;

	msp_pkg::item_ctrl_t ctrl_in, ctrl_s3;
	logic signed [COORD_BITS-1:0] pt_in [3];
	logic signed [COORD_BITS-1:0] pt_s3 [3];
	logic signed [COORD_BITS+25:0] score_s3;
	logic adv;
	logic cap;
	logic busy;

	logic signed [COORD_BITS-1:0]   far_pt [2][3];
	logic signed [COORD_BITS-1:0]   near_pt [2][3];
	logic [msp_pkg::INDEX_BITS-1:0] far_idx [2];
	logic [msp_pkg::INDEX_BITS-1:0] near_idx [2];

	msp_pkg::result_kind_t          out_kind;
	logic signed [COORD_BITS:0]     out_far [3];
	logic signed [COORD_BITS-1:0]   out_near [3];
	logic [msp_pkg::INDEX_BITS-1:0] out_far_idx, out_near_idx;

	// the pipeline holds only while a closing request waits for the emitter
	assign adv = !(ctrl_s3.valid && ctrl_s3.end_of_query && busy);
	assign s_axis_tready = adv;

	assign ctrl_in.valid         = s_axis_tvalid;
	assign ctrl_in.set_select    = s_axis_tuser[0];
	assign ctrl_in.carries_point = s_axis_tuser[1];
	assign ctrl_in.end_of_query  = s_axis_tlast;
	assign pt_in[0] = s_axis_tdata[COORD_BITS-1:0];
	assign pt_in[1] = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign pt_in[2] = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];

	msp_dot #(
		.COORD_BITS(COORD_BITS)
	) u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.adv      (adv),
		.ctrl_in  (ctrl_in),
		.pt_in    (pt_in),
		.ctrl_s3  (ctrl_s3),
		.pt_s3    (pt_s3),
		.score_s3 (score_s3)
	);

	msp_track #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctrl_s3 (ctrl_s3),
		.pt_s3   (pt_s3),
		.score_s3(score_s3),
		.cap     (cap),
		.far_pt  (far_pt),
		.far_idx (far_idx),
		.near_pt (near_pt),
		.near_idx(near_idx)
	);

	msp_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap         (cap),
		.far_pt      (far_pt),
		.far_idx     (far_idx),
		.near_pt     (near_pt),
		.near_idx    (near_idx),
		.busy        (busy),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_kind    (out_kind),
		.out_far     (out_far),
		.out_far_idx (out_far_idx),
		.out_near    (out_near),
		.out_near_idx(out_near_idx),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tuser = out_kind;
	assign m_axis_tdata = OUT_W'({out_near_idx, out_near[2], out_near[1], out_near[0],
		out_far_idx, out_far[2], out_far[1], out_far[0]});

endmodule

// File: bench/support_checker.sv
module support_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [msp_pkg::REG_BITS-1:0]       cfg_wdata,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	// point_x, point_y, point_z
	input  logic [71:0]                        s_axis_tdata,
	// set_select, carries_point
	input  logic [1:0]                         s_axis_tuser,
	input  logic                               s_axis_tlast,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// furthest_x, furthest_y, furthest_z, far_point_index,
	// closest_x, closest_y, closest_z, near_point_index
	input  logic [175:0]                       m_axis_tdata,
	// result_kind
	input  logic [1:0]                         m_axis_tuser,
	input  logic                               m_axis_tlast,
	output int                                 fail_count,
	output int                                 outstanding
);

	localparam logic [msp_pkg::INDEX_BITS-1:0] INDEX_CAP =
		msp_pkg::INDEX_BITS'(msp_pkg::DEF_MAX_POINTS - 1);

	typedef struct packed {
		msp_pkg::result_kind_t kind;
		logic signed [24:0]  far_x;
		logic signed [24:0]  far_y;
		logic signed [24:0]  far_z;
		logic [11:0]         far_idx;
		logic signed [23:0]  near_x;
		logic signed [23:0]  near_y;
		logic signed [23:0]  near_z;
		logic [11:0]         near_idx;
		logic                last;
	} support_t;

	logic signed [msp_pkg::REG_BITS-1:0] axis_q [3];
	logic [msp_pkg::INDEX_BITS-1:0] set_count [2];
	bit                           set_seen [2];
	logic signed [49:0]           high_score [2];
	logic signed [49:0]           low_score [2];
	logic signed [23:0]           far_pt [2][3];
	logic signed [23:0]           near_pt [2][3];
	logic [msp_pkg::INDEX_BITS-1:0] far_at [2];
	logic [msp_pkg::INDEX_BITS-1:0] near_at [2];
	support_t                     support_due [$];

	task automatic clear_query();
		foreach (set_count[s]) begin
			set_count[s] = '0;
			set_seen[s] = 1'b0;
			high_score[s] = '0;
			low_score[s] = '0;
			far_at[s] = '0;
			near_at[s] = '0;
			for (int k = 0; k < 3; k++) begin
				far_pt[s][k] = '0;
				near_pt[s][k] = '0;
			end
		end
	endtask

	task automatic absorb_point(input logic signed [23:0] px, py, pz, input bit s);
		logic signed [49:0] score;
		logic [msp_pkg::INDEX_BITS-1:0] idx;
		score = px * axis_q[0] + py * axis_q[1] + pz * axis_q[2];
		// set b is searched along the opposite direction
		if (s)
			score = -score;
		idx = set_count[s];
		if (set_count[s] != INDEX_CAP)
			set_count[s]++;
		// strict compares keep the earliest point on a tie
		if (!set_seen[s] || score > high_score[s]) begin
			high_score[s] = score;
			far_at[s] = idx;
			far_pt[s][0] = px;
			far_pt[s][1] = py;
			far_pt[s][2] = pz;
		end
		if (!set_seen[s] || score < low_score[s]) begin
			low_score[s] = score;
			near_at[s] = idx;
			near_pt[s][0] = px;
			near_pt[s][1] = py;
			near_pt[s][2] = pz;
		end
		set_seen[s] = 1'b1;
	endtask

	function automatic support_t set_support(input bit s);
		support_t r;
		r = '0;
		r.kind = s ? msp_pkg::KIND_SET_B : msp_pkg::KIND_SET_A;
		if (set_seen[s]) begin
			r.far_x = far_pt[s][0];
			r.far_y = far_pt[s][1];
			r.far_z = far_pt[s][2];
			r.far_idx = far_at[s];
			r.near_x = near_pt[s][0];
			r.near_y = near_pt[s][1];
			r.near_z = near_pt[s][2];
			r.near_idx = near_at[s];
		end
		return r;
	endfunction

	// an empty set stands in as the origin
	function automatic logic signed [23:0] far_coord(input bit s, input int k);
		return set_seen[s] ? far_pt[s][k] : 24'sd0;
	endfunction

	task automatic close_query();
		support_t d;
		support_due.push_back(set_support(1'b0));
		support_due.push_back(set_support(1'b1));
		d = '0;
		d.kind = msp_pkg::KIND_DIFF;
		d.far_x = far_coord(1'b0, 0) - far_coord(1'b1, 0);
		d.far_y = far_coord(1'b0, 1) - far_coord(1'b1, 1);
		d.far_z = far_coord(1'b0, 2) - far_coord(1'b1, 2);
		d.last = 1'b1;
		support_due.push_back(d);
		clear_query();
	endtask

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		support_t w;
		if (support_due.size() == 0) begin
			$error("result with nothing pending, kind %0d", m_axis_tuser);
			fail_count++;
		end else begin
			w = support_due.pop_front();
			compare_field("result_kind", w.kind, m_axis_tuser);
			compare_field("furthest_x", w.far_x, $signed(m_axis_tdata[24:0]));
			compare_field("furthest_y", w.far_y, $signed(m_axis_tdata[49:25]));
			compare_field("furthest_z", w.far_z, $signed(m_axis_tdata[74:50]));
			compare_field("far_point_index", w.far_idx, m_axis_tdata[86:75]);
			compare_field("closest_x", w.near_x, $signed(m_axis_tdata[110:87]));
			compare_field("closest_y", w.near_y, $signed(m_axis_tdata[134:111]));
			compare_field("closest_z", w.near_z, $signed(m_axis_tdata[158:135]));
			compare_field("near_point_index", w.near_idx, m_axis_tdata[170:159]);
			compare_field("last", w.last, m_axis_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0] = msp_pkg::AXIS_X_RESET;
			axis_q[1] = msp_pkg::AXIS_Y_RESET;
			axis_q[2] = msp_pkg::AXIS_Z_RESET;
			clear_query();
			support_due.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					msp_pkg::CFG_AXIS_X: axis_q[0] = cfg_wdata;
					msp_pkg::CFG_AXIS_Y: axis_q[1] = cfg_wdata;
					msp_pkg::CFG_AXIS_Z: axis_q[2] = cfg_wdata;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[1])
					absorb_point(s_axis_tdata[23:0], s_axis_tdata[47:24],
						s_axis_tdata[71:48], s_axis_tuser[0]);
				if (s_axis_tlast)
					close_query();
			end
			outstanding = support_due.size();
		end
	end

endmodule

// File: bench/tb_top.sv
module tb_top;

	localparam int LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 440;
	localparam int TDATA_W = ((3*msp_pkg::DEF_COORD_BITS+7)/8)*8;
	localparam int RDATA_W = ((6*msp_pkg::DEF_COORD_BITS+27+7)/8)*8;
	// no register behind this index
	localparam logic [msp_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam bit SET_A = 1'b0;
	localparam bit SET_B = 1'b1;
	localparam logic signed [23:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] COORD_MIN = 24'sh800000;
	localparam logic signed [23:0] ONE = 24'sd4096;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [msp_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [msp_pkg::REG_BITS-1:0] cfg_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// point_x, point_y, point_z
	logic [TDATA_W-1:0] s_axis_tdata;
	// set_select, carries_point
	logic [1:0] s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// furthest_x, furthest_y, furthest_z, far_point_index,
	// closest_x, closest_y, closest_z, near_point_index
	logic [RDATA_W-1:0] m_axis_tdata;
	// result_kind
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	int fail_count;
	int outstanding;
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;

	always #5 clk = ~clk;

	minkowski_support_point uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	support_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 8);
			end
		end
	end

	function automatic logic signed [23:0] rnd_small();
		return 24'($urandom_range(16)) - 24'd8;
	endfunction

	function automatic logic signed [23:0] rnd_coord();
		case ($urandom_range(5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2, 3: return rnd_small();
			default: return 24'($urandom());
		endcase
	endfunction

	function automatic logic signed [23:0] rnd_axis();
		case ($urandom_range(7))
			0: return 24'sd0;
			1: return ONE;
			2: return -ONE;
			3: return COORD_MAX;
			4: return COORD_MIN;
			5: return rnd_small();
			default: return 24'($urandom());
		endcase
	endfunction

	task automatic send_req(input logic signed [23:0] px, py, pz, input bit sel, cp, eoq);
		bit rdy;
		while (!quiet && $urandom_range(99) < 8) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {pz, py, px};
		s_axis_tuser <= {cp, sel};
		s_axis_tlast <= eoq;
		do begin
			@(negedge clk);
			rdy = s_axis_tready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// drains every pending result, then lets the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [msp_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [msp_pkg::REG_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_axis(input logic signed [23:0] ax, ay, az, input bit poke_spare);
		wait_idle();
		if (poke_spare)
			write_reg(CFG_SPARE, 24'($urandom()));
		write_reg(msp_pkg::CFG_AXIS_X, ax);
		write_reg(msp_pkg::CFG_AXIS_Y, ay);
		write_reg(msp_pkg::CFG_AXIS_Z, az);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sent;
		int next_axis;
		int npts;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset axis: plain x direction
		send_req(24'sd0, 24'sd0, 24'sd0, SET_A, 1'b0, 1'b1);
		send_req(COORD_MAX, COORD_MIN, COORD_MAX, SET_A, 1'b1, 1'b0);
		send_req(COORD_MIN, COORD_MAX, COORD_MIN, SET_A, 1'b1, 1'b0);
		send_req(COORD_MAX, 24'sd0, 24'sd0, SET_A, 1'b1, 1'b0);
		send_req(COORD_MIN, 24'sd5, 24'sd5, SET_A, 1'b1, 1'b0);
		send_req(COORD_MIN, COORD_MIN, COORD_MIN, SET_B, 1'b1, 1'b0);
		send_req(COORD_MAX, COORD_MAX, COORD_MAX, SET_B, 1'b1, 1'b0);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_B, 1'b0, 1'b0);
		send_req(ONE, -ONE, ONE, SET_B, 1'b1, 1'b1);
		send_req(COORD_MAX, COORD_MAX, COORD_MAX, SET_A, 1'b1, 1'b1);
		send_req(COORD_MIN, COORD_MIN, COORD_MIN, SET_B, 1'b1, 1'b1);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_B, 1'b0, 1'b1);

		// largest products of either sign
		set_axis(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
		send_req(COORD_MAX, COORD_MIN, COORD_MAX, SET_A, 1'b1, 1'b0);
		send_req(COORD_MIN, COORD_MAX, COORD_MIN, SET_A, 1'b1, 1'b0);
		send_req(COORD_MAX, COORD_MAX, COORD_MAX, SET_A, 1'b1, 1'b0);
		send_req(COORD_MIN, COORD_MIN, COORD_MIN, SET_B, 1'b1, 1'b0);
		send_req(COORD_MAX, COORD_MIN, COORD_MAX, SET_B, 1'b1, 1'b0);
		send_req(COORD_MIN, COORD_MAX, COORD_MIN, SET_B, 1'b1, 1'b1);

		// zero axis: every score ties
		set_axis(24'sd0, 24'sd0, 24'sd0, 1'b0);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_A, 1'b1, 1'b0);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_A, 1'b1, 1'b0);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_B, 1'b1, 1'b0);
		send_req(rnd_coord(), rnd_coord(), rnd_coord(), SET_B, 1'b1, 1'b1);

		sent = 0;
		next_axis = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= next_axis) begin
				set_axis(rnd_axis(), rnd_axis(), rnd_axis(), 1'b0);
				next_axis += 60;
			end
			if (sent >= 100)
				hold_go = 1'b1;
			quiet = (sent >= 250 && sent < 350);
			npts = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
			for (int i = 0; i < npts; i++) begin
				if ($urandom_range(11) == 0)
					send_req(rnd_coord(), rnd_coord(), rnd_coord(),
						bit'($urandom_range(1)), 1'b0, 1'b0);
				send_req(rnd_coord(), rnd_coord(), rnd_coord(),
					bit'($urandom_range(1)), 1'b1, 1'b0);
				sent++;
			end
			send_req(rnd_coord(), rnd_coord(), rnd_coord(),
				bit'($urandom_range(1)), bit'($urandom_range(1)), 1'b1);
			sent++;
		end

		wait_idle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/msp_pkg.sv
rtl/msp_dot.sv
rtl/msp_track.sv
rtl/msp_emit.sv
rtl/minkowski_support_point.sv
bench/support_checker.sv
bench/tb_top.sv
